>>> hdl/battery_meter_display_encoder_unit_assert.svh
// Assertion macros for the battery meter display encoder checker.
`ifndef BATTERY_METER_DISPLAY_ENCODER_UNIT_ASSERT_SVH
`define BATTERY_METER_DISPLAY_ENCODER_UNIT_ASSERT_SVH

// Clocked check, quiet while reset is held.
`define BMDE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also runs through reset.
`define BMDE_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/bmde_pkg.sv
package bmde_pkg;

  typedef struct packed {
    logic signed [15:0] voltage_sample;
    logic [7:0]         status_byte;
  } in_item_t;

  typedef struct packed {
    logic [28:0] display_word;
    logic        wiring_error;
  } out_item_t;

  localparam int unsigned PctModeBit   = 4;
  localparam logic [13:0] MvOffset     = 14'd3000;
  localparam logic [6:0]  PctMax       = 7'd100;

  // Display word bit positions
  localparam int unsigned PctSignBit   = 0;
  localparam int unsigned VoltSignBit  = 1;
  localparam int unsigned PointBit     = 2;
  localparam int unsigned RightLsb     = 3;
  localparam int unsigned MiddleLsb    = 10;
  localparam int unsigned LeftLsb      = 17;
  localparam int unsigned BarLsb       = 24;

  // Seven-segment pattern, segments g..a from bit 6 down to bit 0
  function automatic logic [6:0] seg_of_digit(input logic [3:0] digit);
    logic [6:0] seg;
    case (digit)
      4'd0:    seg = 7'b0111111;
      4'd1:    seg = 7'b0000110;
      4'd2:    seg = 7'b1011011;
      4'd3:    seg = 7'b1001111;
      4'd4:    seg = 7'b1100110;
      4'd5:    seg = 7'b1101101;
      4'd6:    seg = 7'b1111101;
      4'd7:    seg = 7'b0000111;
      4'd8:    seg = 7'b1111111;
      4'd9:    seg = 7'b1101111;
      default: seg = 7'b0000000;
    endcase
    return seg;
  endfunction

  function automatic logic [4:0] bar_bits(input logic [6:0] pct);
    logic [4:0] bars;
    if (pct >= 7'd90) begin
      bars = 5'b11111;
    end else if (pct >= 7'd70) begin
      bars = 5'b01111;
    end else if (pct >= 7'd50) begin
      bars = 5'b00111;
    end else if (pct >= 7'd30) begin
      bars = 5'b00011;
    end else if (pct >= 7'd5) begin
      bars = 5'b00001;
    end else begin
      bars = 5'b00000;
    end
    return bars;
  endfunction

endpackage

>>> hdl/battery_meter_display_encoder_unit.sv
// An accepted request is held in the input register, encoded combinationally and captured in the output register.
// Throughput: one request per cycle while out_stall is low; the input register and the result register
// form a two-entry pipeline, so a new request is taken while a result waits.
// Digit extraction uses constant reciprocal multiplies in one pass between them.
// Reset (rst_n low, synchronous) empties both registers; no other state.
module battery_meter_display_encoder_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  bmde_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output bmde_pkg::out_item_t out_data
);

  logic                s1_valid_r, s1_valid_nxt;
  bmde_pkg::in_item_t  s1_data_r;
  logic                out_valid_r, out_valid_nxt;
  bmde_pkg::out_item_t out_data_r, res_nxt;
  logic                s2_free;

  assign s2_free  = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s2_free;

  always_comb begin
    s1_valid_nxt  = in_stall ? s1_valid_r : in_valid;
    out_valid_nxt = s2_free ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
    if (s1_valid_r && s2_free) begin
      out_data_r <= res_nxt;
    end
  end

  // Encode the held request
  always_comb begin
    logic [13:0] mv;
    logic [13:0] mv_diff;
    logic [6:0]  pct;
    logic [14:0] pct_prod;
    logic [3:0]  pct_q;
    logic [6:0]  pct_r_w;
    logic [3:0]  pct_r, pct_m;
    logic        pct_l;
    logic [14:0] mv5;
    logic [30:0] p_t10;
    logic [27:0] p_t100;
    logic [26:0] p_q100;
    logic [28:0] p_q1000;
    logic [11:0] t10;
    logic [8:0]  t100;
    logic [7:0]  q100;
    logic [4:0]  q1000;
    logic [11:0] volt_r_w;
    logic [7:0]  volt_m_w;
    logic [3:0]  volt_l;
    logic [28:0] word;

    mv      = s1_data_r.voltage_sample[14:1];
    mv_diff = mv - bmde_pkg::MvOffset;
    if (mv <= bmde_pkg::MvOffset) begin
      pct = '0;
    end else if (mv_diff[13:3] > 11'(bmde_pkg::PctMax)) begin
      pct = bmde_pkg::PctMax;
    end else begin
      pct = mv_diff[9:3];
    end

    // pct / 10 via 205 / 2048, exact below 1024
    pct_prod = 15'(pct) * 15'd205;
    pct_q    = pct_prod[14:11];
    pct_r_w  = pct - 7'(pct_q) * 7'd10;
    pct_r    = pct_r_w[3:0];
    pct_l    = (pct == bmde_pkg::PctMax);
    pct_m    = pct_l ? 4'd0 : pct_q;

    // Volt digits: parallel reciprocal quotients, then remainder by subtraction
    mv5      = 15'(mv) + 15'd5;
    p_t10    = 31'(mv5) * 31'd52429;
    p_t100   = 28'(mv5) * 28'd5243;
    p_q100   = 27'(mv) * 27'd5243;
    p_q1000  = 29'(mv) * 29'd16778;
    t10      = p_t10[30:19];
    t100     = p_t100[27:19];
    q100     = p_q100[26:19];
    q1000    = p_q1000[28:24];
    volt_r_w = t10 - 12'(t100) * 12'd10;
    volt_m_w = q100 - 8'(q1000) * 8'd10;
    volt_l   = (q1000 >= 5'd10) ? 4'(q1000 - 5'd10) : q1000[3:0];

    word = '0;
    if (s1_data_r.status_byte[bmde_pkg::PctModeBit]) begin
      word[bmde_pkg::RightLsb +: 7] = bmde_pkg::seg_of_digit(pct_r);
      if (pct_l) begin
        word[bmde_pkg::LeftLsb +: 7]   = bmde_pkg::seg_of_digit(4'd1);
        word[bmde_pkg::MiddleLsb +: 7] = bmde_pkg::seg_of_digit(pct_m);
      end else if (pct_m != 4'd0) begin
        word[bmde_pkg::MiddleLsb +: 7] = bmde_pkg::seg_of_digit(pct_m);
      end
      word[bmde_pkg::PctSignBit] = 1'b1;
    end else begin
      word[bmde_pkg::RightLsb +: 7]  = bmde_pkg::seg_of_digit(volt_r_w[3:0]);
      word[bmde_pkg::MiddleLsb +: 7] = bmde_pkg::seg_of_digit(volt_m_w[3:0]);
      word[bmde_pkg::LeftLsb +: 7]   = bmde_pkg::seg_of_digit(volt_l);
      word[bmde_pkg::VoltSignBit]    = 1'b1;
      word[bmde_pkg::PointBit]       = 1'b1;
    end
    word[bmde_pkg::BarLsb +: 5] = bmde_pkg::bar_bits(pct);

    // Miswired sensor: flag and blank the word
    if (s1_data_r.voltage_sample[15]) begin
      res_nxt.display_word = '0;
      res_nxt.wiring_error = 1'b1;
    end else begin
      res_nxt.display_word = word;
      res_nxt.wiring_error = 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hdl/bmde_checker.sv
`include "battery_meter_display_encoder_unit_assert.svh"

module bmde_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input bmde_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input bmde_pkg::out_item_t out_data
);

  logic [4:0] bars;
  logic       in_seen;

  assign bars    = out_data.display_word[bmde_pkg::BarLsb +: 5];
  assign in_seen = in_valid && (in_data.voltage_sample[15] || !in_data.voltage_sample[15]);

  `BMDE_ASSERT_RST(a_reset_empties, !rst_n |=> !out_valid, "result valid right after reset")
  `BMDE_ASSERT(a_hold_stalled, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result changed")
  `BMDE_ASSERT(a_error_blank, out_valid && out_data.wiring_error |-> out_data.display_word == '0, "wiring error with non-blank word")
  `BMDE_ASSERT(a_mode_bits, out_valid && !out_data.wiring_error |-> out_data.display_word[bmde_pkg::PctSignBit] != out_data.display_word[bmde_pkg::VoltSignBit], "percent and volt marks disagree")
  `BMDE_ASSERT(a_bar_fill, out_valid && in_seen |-> bars == 5'b00000 || bars == 5'b00001 || bars == 5'b00011 || bars == 5'b00111 || bars == 5'b01111 || bars == 5'b11111 || !in_seen, "level bars not contiguous")

endmodule

bind battery_meter_display_encoder_unit bmde_checker u_bmde_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

>>> tb/battery_meter_display_encoder_unit_tb.sv
`timescale 1ns / 1ps

module battery_meter_display_encoder_unit_tb;

  localparam int unsigned IdleLimit   = 3000;
  localparam int unsigned DrainSlack  = 6;
  localparam int unsigned ReportCap   = 40;
  localparam int unsigned LongHoldOff = 400;

  // Segment patterns, g..a from bit 6 down to bit 0
  localparam logic [6:0] SegPattern [0:9] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  bmde_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_stall;
  bmde_pkg::out_item_t out_data;

  bmde_pkg::out_item_t pending_displays[$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;
  int          hold_off_req   = 0;
  int          hold_left      = 0;
  int          run_left       = 0;
  int unsigned rx_stall_pct   = 0;

  battery_meter_display_encoder_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bmde_pkg::out_item_t expected_display(input bmde_pkg::in_item_t req);
    bmde_pkg::out_item_t res;
    logic [28:0] word;
    int unsigned mv;
    int unsigned pct;
    int unsigned right_d;
    int unsigned mid_d;
    int unsigned left_d;
    res  = '0;
    word = '0;
    if (req.voltage_sample[15]) begin
      res.wiring_error = 1'b1;
      return res;
    end
    mv  = req.voltage_sample[14:0] >> 1;
    pct = (mv > bmde_pkg::MvOffset) ? (mv - bmde_pkg::MvOffset) / 8 : 0;
    if (pct > bmde_pkg::PctMax) pct = bmde_pkg::PctMax;
    if (req.status_byte[bmde_pkg::PctModeBit]) begin
      right_d = pct % 10;
      mid_d   = (pct / 10) % 10;
      left_d  = (pct / 100) % 10;
      word[bmde_pkg::RightLsb +: 7] = SegPattern[right_d];
      // blank leading zeros
      if (left_d != 0) begin
        word[bmde_pkg::LeftLsb +: 7]   = SegPattern[left_d];
        word[bmde_pkg::MiddleLsb +: 7] = SegPattern[mid_d];
      end else if (mid_d != 0) begin
        word[bmde_pkg::MiddleLsb +: 7] = SegPattern[mid_d];
      end
      word[bmde_pkg::PctSignBit] = 1'b1;
    end else begin
      // rounding stays in the right digit, no carry
      right_d = ((mv + 5) / 10) % 10;
      mid_d   = (mv / 100) % 10;
      left_d  = (mv / 1000) % 10;
      word[bmde_pkg::RightLsb +: 7]  = SegPattern[right_d];
      word[bmde_pkg::MiddleLsb +: 7] = SegPattern[mid_d];
      word[bmde_pkg::LeftLsb +: 7]   = SegPattern[left_d];
      word[bmde_pkg::VoltSignBit]    = 1'b1;
      word[bmde_pkg::PointBit]       = 1'b1;
    end
    if (pct >= 90) begin
      word[bmde_pkg::BarLsb +: 5] = 5'b11111;
    end else if (pct >= 70) begin
      word[bmde_pkg::BarLsb +: 5] = 5'b01111;
    end else if (pct >= 50) begin
      word[bmde_pkg::BarLsb +: 5] = 5'b00111;
    end else if (pct >= 30) begin
      word[bmde_pkg::BarLsb +: 5] = 5'b00011;
    end else if (pct >= 5) begin
      word[bmde_pkg::BarLsb +: 5] = 5'b00001;
    end
    res.display_word = word;
    return res;
  endfunction

  function automatic bmde_pkg::in_item_t random_request();
    bmde_pkg::in_item_t req;
    int unsigned        pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      req.voltage_sample = {1'b1, 15'($urandom)};
    end else if (pick <= 2) begin
      req.voltage_sample = 16'($urandom);
    end else begin
      // mostly around the percent band, including clamp above 100
      req.voltage_sample = 16'($urandom_range(5800, 8200));
    end
    req.status_byte = 8'($urandom);
    return req;
  endfunction

  // Offer one request and hold it until accepted; valid stays high on return
  task automatic send_request(input bmde_pkg::in_item_t req);
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_displays.push_back(expected_display(req));
  endtask

  task automatic send_in_both_modes(input logic signed [15:0] sample);
    send_request('{voltage_sample: sample, status_byte: 8'h00});
    send_request('{voltage_sample: sample, status_byte: 8'hFF});
  endtask

  task automatic idle_gap(input int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic wait_until_drained();
    in_valid <= 1'b0;
    while (pending_displays.size() != 0) @(posedge clk);
    repeat (DrainSlack) @(posedge clk);
  endtask

  task automatic test_field_extremes();
    send_in_both_modes(16'sh0000);
    send_in_both_modes(16'sh7FFF);
    send_in_both_modes(-16'sd1);
    send_in_both_modes(16'sh8000);
    // other status bits must not matter
    send_request('{voltage_sample: 16'sd7000, status_byte: 8'hEF});
    send_request('{voltage_sample: 16'sd7000, status_byte: 8'h10});
    wait_until_drained();
  endtask

  task automatic test_percent_thresholds();
    int unsigned levels [12] = '{4, 5, 29, 30, 49, 50, 69, 70, 89, 90, 100, 101};
    foreach (levels[i]) begin
      // mv = 3000 + 8 * pct
      send_request('{voltage_sample: 16'(6000 + 16 * levels[i]),
                     status_byte: (i % 2 == 0) ? 8'h10 : 8'h00});
    end
    send_request('{voltage_sample: 16'sd6002, status_byte: 8'h10});
    wait_until_drained();
  endtask

  task automatic test_volt_rounding();
    send_request('{voltage_sample: 16'sd7990, status_byte: 8'h00});
    send_request('{voltage_sample: 16'sd7991, status_byte: 8'h00});
    send_request('{voltage_sample: 16'sd6009, status_byte: 8'h00});
    send_request('{voltage_sample: 16'sd19999, status_byte: 8'h00});
    wait_until_drained();
  endtask

  // Receiver holds off while the sender keeps offering; the block must back up
  task automatic test_output_hold_off();
    rx_stall_pct = 0;
    hold_off_req = LongHoldOff;
    repeat (40) send_request(random_request());
    wait_until_drained();
  endtask

  task automatic test_random_traffic(input int unsigned count, input int unsigned gap_max,
                                     input int unsigned stall_pct);
    int unsigned burst_left;
    burst_left   = 0;
    rx_stall_pct = stall_pct;
    for (int unsigned n = 0; n < count; n++) begin
      if (burst_left == 0) begin
        if (gap_max > 0) idle_gap($urandom_range(1, gap_max));
        burst_left = $urandom_range(1, 16);
      end
      send_request(random_request());
      burst_left--;
      if (n % 200 == 199) wait_until_drained();
    end
    wait_until_drained();
  endtask

  // Receiver: random on/off runs, with an occasional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
      run_left  = 0;
    end else if (hold_off_req > 0) begin
      hold_left    = hold_off_req;
      hold_off_req = 0;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (run_left > 0) begin
      run_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_stall_pct);
      run_left = $urandom_range(0, 7);
    end
  end

  always @(posedge clk) begin : check_results
    bmde_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_displays.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportCap) $error("result with no request outstanding");
      end else begin
        want = pending_displays.pop_front();
        if (out_data.display_word !== want.display_word) begin
          mismatch_count++;
          if (mismatch_count <= ReportCap)
            $error("display_word: expected 0x%07h, got 0x%07h",
                   want.display_word, out_data.display_word);
        end
        if (out_data.wiring_error !== want.wiring_error) begin
          mismatch_count++;
          if (mismatch_count <= ReportCap)
            $error("wiring_error: expected %0b, got %0b",
                   want.wiring_error, out_data.wiring_error);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_extremes();
    test_percent_thresholds();
    test_volt_rounding();
    test_output_hold_off();
    test_random_traffic(250, 0, 0);
    test_random_traffic(700, 6, 30);
    test_random_traffic(250, 3, 75);

    wait_until_drained();
    if (pending_displays.size() != 0) begin
      mismatch_count++;
      $error("%0d results never arrived", pending_displays.size());
    end
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
